// File: rtl/cmux_basic_frame_receiver_macros.svh
// Assertion macros for the basic-mode multiplexer frame receiver.
// Used by the top level only; needs no other file.
`ifndef CMUX_BASIC_FRAME_RECEIVER_MACROS_SVH
`define CMUX_BASIC_FRAME_RECEIVER_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define CMUXR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, disabled during reset.
`define CMUXR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cmuxr_pkg.sv
// Shared types and constants of the multiplexer frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package cmuxr_pkg;

  // Frame delimiters and control codes.
  localparam logic [7:0] SOF_FLAG   = 8'hF9;
  localparam logic [7:0] CTL_UA_PF  = 8'h73;
  localparam logic [7:0] CTL_UIH_PF = 8'hFF;

  // Reflected CRC-8 used for the FCS.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'hE0;
  localparam logic [7:0] FCS_BASE = 8'hFF;

  // Result event codes.
  localparam logic [2:0] EV_GOOD     = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_FCS_ERR  = 3'd2;
  localparam logic [2:0] EV_FLAG_ERR = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;
  localparam logic [2:0] EV_UNKNOWN  = 3'd5;

  // Channel state codes.
  localparam logic [1:0] CS_CLOSED  = 2'd0;
  localparam logic [1:0] CS_OPENING = 2'd1;
  localparam logic [1:0] CS_OPEN    = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OUT  = 4'b0010,
    S_RD   = 4'b0100,
    S_LOAD = 4'b1000
  } seq_state_t;

  // Control of the header checksum unit.
  typedef struct packed {
    logic       clear;
    logic       update;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/cmuxr_crc.sv
// Header checksum unit: folds one byte per enabled cycle into a CRC-8.
// Depends on cmuxr_pkg.
`default_nettype none

module cmuxr_crc
  import cmuxr_pkg::*;
(
  input  wire logic      clk,
  input  wire crc_ctrl_t ctrl,
  output logic [7:0]     crc
);

  logic [7:0] crc_next;

  // Bitwise reflected CRC over one byte.
  always_comb begin
    crc_next = crc ^ ctrl.data;
    for (int i = 0; i < 8; i++) begin
      crc_next = crc_next[0] ? ((crc_next >> 1) ^ CRC_POLY) : (crc_next >> 1);
    end
  end

  // The register is restarted at each opening flag.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc <= CRC_INIT;
    end else if (ctrl.update) begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cmuxr_store.sv
// Frame byte store: one write port and one registered read port.
// Depends on cmuxr_pkg.
`default_nettype none

module cmuxr_store
  import cmuxr_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];

  // Write of each kept byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read for the payload sweep.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/cmux_basic_frame_receiver.sv
// Basic-mode multiplexer frame receiver: top level with the byte sequencer.
// Depends on cmuxr_pkg, cmuxr_crc, cmuxr_store and the macros header.
//
// Usage: received bytes enter on rx_byte with in_valid; a transaction takes
// place when in_valid is high and in_stall is low. Results leave on the
// output fields with out_valid and are taken when out_stall is low.
// A byte that completes nothing gives no result and does not hold the input.
// A byte that closes a frame or overflows the store gives one result that
// is ready in the cycle after the byte; the next byte is taken once that
// result has been taken. A good UIH frame with P/F set and payload on an
// open or opening channel gives one result per payload byte, each read
// from the frame store through the steps read address, registered read
// data and output register; the input is held until the last is taken.
// The last result caused by a byte carries last high.
// While out_stall is high the result register holds its value and
// in_stall stays high. Reset returns the sequencer to idle, drops any
// partial frame, clears the counters and leaves channel 0 opening.
`default_nettype none

module cmux_basic_frame_receiver
  import cmuxr_pkg::*;
#(
  parameter int MAX_FRAME     = 64,
  parameter int DATA_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_res,
  output logic [5:0]       channel,
  output logic [7:0]       control,
  output logic [7:0]       data_byte,
  output logic             last,
  output logic             open_next,
  output logic [1:0]       chan_state,
  output logic             mux_up,
  output logic [15:0]      error_count,
  output logic [15:0]      good_count
);

  localparam int WPW = $clog2(MAX_FRAME + 1);
  localparam int AW  = $clog2(MAX_FRAME);
  localparam int PW  = $clog2(DATA_CHANNELS + 2);
  localparam logic [WPW-1:0] WP_FULL = WPW'(MAX_FRAME);
  localparam logic [5:0]     DC_CH   = 6'(DATA_CHANNELS);
  localparam logic [PW-1:0]  P_ALL   = PW'(DATA_CHANNELS + 1);

  seq_state_t     state;
  logic [WPW-1:0] write_pos;
  logic [15:0]    expected_len;
  logic           second_len_pending;
  logic [2:0]     payload_start;
  logic [5:0]     ch_reg;
  logic [7:0]     ctl_reg;
  logic [7:0]     prev_byte;
  // Channels below open_ptr are open, open_ptr itself is opening.
  logic [PW-1:0]  open_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW-1:0]  end_ptr;

  logic [7:0]     crc;
  logic [7:0]     rd_data;
  crc_ctrl_t      crc_ctrl;
  logic           take;

  // Byte decode signals.
  logic           ovf;
  logic [WPW-1:0] wpe;
  logic [WPW-1:0] wpn;
  logic [WPW-1:0] fcs_pos;
  logic [15:0]    exp_cur;
  logic [15:0]    exp_next;
  logic           spend_cur;
  logic           spend_next;
  logic [2:0]     ps_next;
  logic           keep;
  logic           finish;
  logic [15:0]    err_sat;
  logic           fcs_ok;
  logic           known;
  logic           ua;
  logic [PW-1:0]  p_next;
  logic [1:0]     st_after;
  logic [1:0]     st_now;
  logic           deliver;

  function automatic logic [1:0] state_of(logic [5:0] ch, logic [PW-1:0] p);
    logic [1:0] s;
    if (ch > DC_CH) begin
      s = CS_CLOSED;
    end else if (ch < 6'(p)) begin
      s = CS_OPEN;
    end else if (ch == 6'(p)) begin
      s = CS_OPENING;
    end else begin
      s = CS_CLOSED;
    end
    return s;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && (state == S_IDLE);

  // Decode of one received byte against the frame position.
  always_comb begin
    ovf        = (write_pos == WP_FULL);
    wpe        = ovf ? '0 : write_pos;
    exp_cur    = ovf ? '0 : expected_len;
    spend_cur  = ovf ? 1'b0 : second_len_pending;
    ps_next    = ovf ? 3'd0 : payload_start;
    keep       = !((wpe == '0) && (rx_byte != SOF_FLAG)) &&
                 !((wpe == WPW'(1)) && (rx_byte == SOF_FLAG));
    wpn        = wpe + WPW'(1);
    exp_next   = exp_cur;
    spend_next = spend_cur;
    if (keep) begin
      if (wpn == WPW'(4)) begin
        spend_next = !rx_byte[0];
        exp_next   = {9'd0, rx_byte[7:1]} + (spend_next ? 16'd7 : 16'd6);
        ps_next    = spend_next ? 3'd5 : 3'd4;
      end else if ((wpn == WPW'(5)) && spend_cur) begin
        exp_next   = exp_cur + {1'b0, rx_byte, 7'd0};
        spend_next = 1'b0;
      end
    end
    finish   = keep && (16'(wpn) == exp_next);
    fcs_pos  = wpn - WPW'(2);
    err_sat  = (error_count == 16'hFFFF) ? error_count : error_count + 16'd1;
    fcs_ok   = ((FCS_BASE - crc) == prev_byte);
    known    = (ch_reg <= DC_CH);
    ua       = known && (ch_reg == 6'(open_ptr)) && (ctl_reg == CTL_UA_PF);
    p_next   = ua ? open_ptr + PW'(1) : open_ptr;
    st_after = state_of(ch_reg, p_next);
    st_now   = state_of(ch_reg, open_ptr);
    deliver  = ((st_after == CS_OPENING) || (st_after == CS_OPEN)) &&
               (ctl_reg == CTL_UIH_PF) && (fcs_pos > WPW'(ps_next));
  end

  // Header bytes 1 to 3, and the second length byte, feed the checksum.
  always_comb begin
    crc_ctrl.data   = rx_byte;
    crc_ctrl.clear  = take && keep && (wpe == '0);
    crc_ctrl.update = take && keep &&
                      ((wpe == WPW'(1)) || (wpe == WPW'(2)) || (wpe == WPW'(3)) ||
                       ((wpe == WPW'(4)) && spend_cur));
  end

  cmuxr_crc u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .crc  (crc)
  );

  cmuxr_store #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (take && keep),
    .wr_addr (wpe[AW-1:0]),
    .wr_data (rx_byte),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // Frame tracking and the result sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      write_pos          <= '0;
      expected_len       <= '0;
      second_len_pending <= 1'b0;
      payload_start      <= '0;
      open_ptr           <= '0;
      error_count        <= '0;
      good_count         <= '0;
      out_valid          <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (keep) begin
              prev_byte <= rx_byte;
              if (wpe == WPW'(1)) begin
                ch_reg <= rx_byte[7:2];
              end
              if (wpe == WPW'(2)) begin
                ctl_reg <= rx_byte;
              end
            end
            if (finish) begin
              write_pos          <= '0;
              expected_len       <= '0;
              second_len_pending <= 1'b0;
              payload_start      <= '0;
            end else begin
              write_pos          <= keep ? wpn : wpe;
              expected_len       <= exp_next;
              second_len_pending <= spend_next;
              payload_start      <= ps_next;
            end
            // Common fields of any result of this byte.
            channel    <= ch_reg;
            control    <= ctl_reg;
            data_byte  <= '0;
            last       <= 1'b1;
            open_next  <= 1'b0;
            chan_state <= st_now;
            mux_up     <= (open_ptr == P_ALL);
            if (ovf) begin
              event_res   <= EV_OVERFLOW;
              error_count <= err_sat;
              out_valid   <= 1'b1;
              state       <= S_OUT;
            end else if (finish) begin
              if (rx_byte != SOF_FLAG) begin
                event_res   <= EV_FLAG_ERR;
                error_count <= err_sat;
                out_valid   <= 1'b1;
                state       <= S_OUT;
              end else if (!fcs_ok) begin
                event_res   <= EV_FCS_ERR;
                error_count <= err_sat;
                out_valid   <= 1'b1;
                state       <= S_OUT;
              end else if (!known) begin
                event_res <= EV_UNKNOWN;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                good_count <= good_count + 16'd1;
                open_ptr   <= p_next;
                open_next  <= ua && (ch_reg < DC_CH);
                chan_state <= st_after;
                mux_up     <= (p_next == P_ALL);
                if (deliver) begin
                  event_res <= EV_PAYLOAD;
                  rd_ptr    <= AW'(ps_next);
                  end_ptr   <= AW'(fcs_pos - WPW'(1));
                  state     <= S_RD;
                end else begin
                  event_res <= EV_GOOD;
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end
              end
            end
          end
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          data_byte <= rd_data;
          last      <= (rd_ptr == end_ptr);
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
              state  <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "cmux_basic_frame_receiver_macros.svh"

  // Input is only taken with the result register empty.
  `CMUXR_ASSERT_NOW(a_idle_empty, clk, rst, !in_stall, !out_valid, "input open with result pending")
  // Only payload runs give more than one result per byte.
  `CMUXR_ASSERT_NOW(a_single_last, clk, rst, out_valid && (event_res != EV_PAYLOAD), last, "non-payload result without last")
  // After a non-final payload result is taken the input stays closed.
  `CMUXR_ASSERT_NEXT(a_run_holds, clk, rst, out_valid && !out_stall && !last, in_stall, "input opened inside a payload run")

endmodule

`default_nettype wire

// File: verif/cmux_frame_checker.sv
// Checker for the multiplexer frame receiver: watches the byte input and the
// result output, predicts the results of every received byte and compares them. Depends on cmuxr_pkg.
`default_nettype none

module cmux_frame_checker
  import cmuxr_pkg::*;
#(
  parameter int MAX_FRAME     = 64,
  parameter int DATA_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  event_res,
  input  wire logic [5:0]  channel,
  input  wire logic [7:0]  control,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic        open_next,
  input  wire logic [1:0]  chan_state,
  input  wire logic        mux_up,
  input  wire logic [15:0] error_count,
  input  wire logic [15:0] good_count,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output int               frames_closed
);

  typedef struct packed {
    logic [2:0]  ev;
    logic [5:0]  ch;
    logic [7:0]  ctl;
    logic [7:0]  data;
    logic        fin;
    logic        onext;
    logic [1:0]  st;
    logic        up;
    logic [15:0] errs;
    logic [15:0] goods;
  } rx_result_t;

  rx_result_t  want_q[$];
  rx_result_t  step_q[$];

  // Shadow copy of the receiver state.
  logic [7:0]  frame_buf [MAX_FRAME];
  int          wr_pos;
  int          frame_len;
  bit          len_ext;
  int          body_start;
  logic [1:0]  link_state [DATA_CHANNELS + 1];
  int          links_open;
  bit          ctl_link_up;
  logic [15:0] err_total;
  logic [15:0] good_total;

  function automatic void add_result(logic [2:0] ev, int ch, logic [7:0] ctl,
                                     logic [7:0] data, logic onext);
    rx_result_t r;
    r.ev    = ev;
    r.ch    = ch[5:0];
    r.ctl   = ctl;
    r.data  = data;
    r.fin   = 1'b0;
    r.onext = onext;
    r.st    = (ch <= DATA_CHANNELS) ? link_state[ch] : CS_CLOSED;
    r.up    = (links_open == DATA_CHANNELS);
    r.errs  = err_total;
    r.goods = good_total;
    step_q.push_back(r);
  endfunction

  function automatic void bump_errors();
    if (err_total != 16'hFFFF) err_total++;
  endfunction

  function automatic logic [7:0] header_crc(logic [7:0] crc, logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Closing byte of a frame: flag, FCS, channel and open handshake.
  function automatic void close_frame(logic [7:0] b);
    logic [7:0] ctl;
    logic [7:0] crc;
    logic [1:0] st;
    int         ch;
    int         fcs_at;
    logic       onext;
    ctl = frame_buf[2];
    ch  = frame_buf[1] >> 2;
    crc = CRC_INIT;
    onext = 1'b0;
    frames_closed++;
    if (b != SOF_FLAG) begin
      bump_errors();
      add_result(EV_FLAG_ERR, ch, ctl, 8'h00, 1'b0);
      return;
    end
    for (int i = 1; i < body_start && i < MAX_FRAME; i++) crc = header_crc(crc, frame_buf[i]);
    fcs_at = frame_len - 2;
    if (fcs_at >= MAX_FRAME || (FCS_BASE - crc) != frame_buf[fcs_at]) begin
      bump_errors();
      add_result(EV_FCS_ERR, ch, ctl, 8'h00, 1'b0);
      return;
    end
    if (ch > DATA_CHANNELS) begin
      add_result(EV_UNKNOWN, ch, ctl, 8'h00, 1'b0);
      return;
    end
    good_total++;
    st = link_state[ch];
    if (st == CS_OPENING && ctl == CTL_UA_PF) begin
      st = CS_OPEN;
      if (ch != 0) begin
        if (links_open < DATA_CHANNELS) links_open++;
      end else begin
        ctl_link_up = 1'b1;
      end
      link_state[ch] = st;
      if (ch < DATA_CHANNELS) begin
        link_state[ch + 1] = CS_OPENING;
        onext = 1'b1;
      end
    end
    if ((st == CS_OPENING || st == CS_OPEN) && ctl == CTL_UIH_PF && fcs_at > body_start) begin
      for (int i = body_start; i < fcs_at && i < MAX_FRAME; i++)
        add_result(EV_PAYLOAD, ch, ctl, frame_buf[i], onext);
      return;
    end
    add_result(EV_GOOD, ch, ctl, 8'h00, onext);
  endfunction

  function automatic void drop_partial();
    wr_pos     = 0;
    frame_len  = 0;
    len_ext    = 1'b0;
    body_start = 0;
  endfunction

  // One received byte: overflow, storing, length decoding and frame end.
  function automatic void predict_byte(logic [7:0] b);
    if (wr_pos >= MAX_FRAME) begin
      drop_partial();
      bump_errors();
      add_result(EV_OVERFLOW, frame_buf[1] >> 2, frame_buf[2], 8'h00, 1'b0);
    end
    if (!(wr_pos == 0 && b != SOF_FLAG) && !(wr_pos == 1 && b == SOF_FLAG)) begin
      frame_buf[wr_pos] = b;
      wr_pos++;
      if (wr_pos == 4) begin
        len_ext    = !b[0];
        frame_len  = (b >> 1) + (len_ext ? 7 : 6);
        body_start = len_ext ? 5 : 4;
      end else if (wr_pos == 5 && len_ext) begin
        frame_len = frame_len + (int'(b) << 7);
        len_ext   = 1'b0;
      end
      if (wr_pos == frame_len) begin
        close_frame(b);
        drop_partial();
      end
    end
    if (step_q.size() > 0) step_q[$].fin = 1'b1;
    while (step_q.size() > 0) want_q.push_back(step_q.pop_front());
  endfunction

  // Compare on every result transaction, then predict on every byte transaction.
  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t exp;
    if (rst) begin
      want_q.delete();
      drop_partial();
      foreach (link_state[i]) link_state[i] = CS_CLOSED;
      link_state[0] = CS_OPENING;
      links_open    = 0;
      ctl_link_up   = 1'b0;
      err_total     = '0;
      good_total    = '0;
      fail_count    = 0;
      results_seen  = 0;
      frames_closed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{event_res, channel, control, data_byte, last, open_next, chan_state,
                mux_up, error_count, good_count};
        results_seen++;
        if (want_q.size() == 0) begin
          if (fail_count < 10) $display("Result with nothing expected: %p", got);
          fail_count++;
        end else begin
          exp = want_q.pop_front();
          if (got !== exp) begin
            if (fail_count < 10) begin
              $display("Mismatch on result %0d:", results_seen);
              $display("  expected ev=%0d ch=%0d ctl=%h data=%h last=%b onext=%b st=%0d up=%b err=%0d good=%0d",
                       exp.ev, exp.ch, exp.ctl, exp.data, exp.fin, exp.onext, exp.st,
                       exp.up, exp.errs, exp.goods);
              $display("  actual   ev=%0d ch=%0d ctl=%h data=%h last=%b onext=%b st=%0d up=%b err=%0d good=%0d",
                       got.ev, got.ch, got.ctl, got.data, got.fin, got.onext, got.st,
                       got.up, got.errs, got.goods);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(rx_byte);
    end
    pending = want_q.size();
  end

endmodule

`default_nettype wire

// File: verif/cmux_basic_frame_receiver_tb.sv
// Testbench top for the multiplexer frame receiver: clock, reset, byte stimulus
// and verdict. Depends on cmuxr_pkg, the receiver RTL and cmux_frame_checker.
`default_nettype none

module cmux_basic_frame_receiver_tb;
  import cmuxr_pkg::*;

  localparam int MAX_FRAME     = 64;
  localparam int DATA_CHANNELS = 4;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_COUNT    = 360;
  localparam int QUIET_FROM    = 300;

  // UIH control code without the poll/final bit.
  localparam logic [7:0] CTL_UIH_NOPF = 8'hEF;

  // Kinds of frame the generator can build.
  typedef enum int {FR_GOOD, FR_BAD_FCS, FR_BAD_FLAG, FR_LONG_LEN, FR_DOUBLE_FLAG} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [5:0]  channel;
  logic [7:0]  control;
  logic [7:0]  data_byte;
  logic        last;
  logic        open_next;
  logic [1:0]  chan_state;
  logic        mux_up;
  logic [15:0] error_count;
  logic [15:0] good_count;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          frames_closed;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  cmux_basic_frame_receiver #(.MAX_FRAME(MAX_FRAME), .DATA_CHANNELS(DATA_CHANNELS)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
    .channel(channel), .control(control), .data_byte(data_byte), .last(last),
    .open_next(open_next), .chan_state(chan_state), .mux_up(mux_up),
    .error_count(error_count), .good_count(good_count)
  );

  cmux_frame_checker #(.MAX_FRAME(MAX_FRAME), .DATA_CHANNELS(DATA_CHANNELS)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
    .channel(channel), .control(control), .data_byte(data_byte), .last(last),
    .open_next(open_next), .chan_state(chan_state), .mux_up(mux_up),
    .error_count(error_count), .good_count(good_count), .fail_count(fail_count),
    .pending(pending), .results_seen(results_seen), .frames_closed(frames_closed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts, switched off in the quiet tail.
  initial begin
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  // Sends one byte, with an occasional idle burst in front of it.
  task automatic put_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] fold_crc(logic [7:0] crc, logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Builds and sends one frame; a long length field leads to a store overflow.
  task automatic send_frame(input int ch, input logic [7:0] ctl, input int n,
                            input frame_kind_t kind);
    logic [7:0] hdr[$];
    logic [7:0] crc;
    logic [7:0] addr;
    int         len;
    addr = {ch[5:0], 2'($urandom_range(0, 3))};
    len  = (kind == FR_LONG_LEN) ? $urandom_range(200, 4000) : n;
    hdr  = {addr, ctl};
    if (len > 127 || $urandom_range(0, 7) == 0) begin
      hdr.push_back({len[6:0], 1'b0});
      hdr.push_back(len[14:7]);
    end else begin
      hdr.push_back({len[6:0], 1'b1});
    end
    crc = CRC_INIT;
    foreach (hdr[i]) crc = fold_crc(crc, hdr[i]);
    put_byte(SOF_FLAG);
    if (kind == FR_DOUBLE_FLAG) put_byte(SOF_FLAG);
    foreach (hdr[i]) put_byte(hdr[i]);
    if (kind == FR_LONG_LEN) begin
      // Fill the store past its end, then start over with a flag.
      repeat (MAX_FRAME + 2 - hdr.size()) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat (n) put_byte(8'($urandom_range(0, 255)));
    put_byte(kind == FR_BAD_FCS ? (FCS_BASE - crc) ^ 8'(1 << $urandom_range(0, 7))
                                : FCS_BASE - crc);
    put_byte(kind == FR_BAD_FLAG ? 8'($urandom_range(0, 248)) : SOF_FLAG);
  endtask

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 5))
      0, 1:    return CTL_UIH_PF;
      2:       return CTL_UA_PF;
      3:       return CTL_UIH_NOPF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int          r;
    int          ch;
    int          n;
    frame_kind_t kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: noise, delivery before opening, the open sequence,
    // the errors, unknown channels, an overflow and the largest payload.
    put_byte(8'h00);
    put_byte(8'hFF);
    send_frame(0, CTL_UIH_PF, 3, FR_GOOD);
    send_frame(1, CTL_UA_PF, 0, FR_GOOD);
    for (int c = 0; c <= DATA_CHANNELS; c++) send_frame(c, CTL_UA_PF, 0, FR_GOOD);
    send_frame(2, CTL_UIH_PF, 0, FR_GOOD);
    send_frame(3, CTL_UIH_PF, 2, FR_DOUBLE_FLAG);
    send_frame(1, CTL_UIH_PF, 1, FR_BAD_FCS);
    send_frame(4, CTL_UIH_NOPF, 1, FR_BAD_FLAG);
    send_frame(5, CTL_UIH_PF, 1, FR_GOOD);
    send_frame(63, CTL_UA_PF, 0, FR_GOOD);
    send_frame(2, CTL_UIH_PF, 0, FR_LONG_LEN);
    send_frame(4, CTL_UIH_PF, MAX_FRAME - 6, FR_GOOD);

    // Random part: mostly well-formed frames, some broken ones and noise.
    while (bytes_sent < ITEM_COUNT) begin
      if (bytes_sent > QUIET_FROM) quiet = 1'b1;
      r  = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
      n  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_FRAME - 7)
                                        : $urandom_range(0, 6);
      if (r < 4) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        kind = (r < 72) ? FR_GOOD : (r < 82) ? FR_BAD_FCS : (r < 90) ? FR_BAD_FLAG :
               (r < 95) ? FR_DOUBLE_FLAG : FR_LONG_LEN;
        send_frame(ch, pick_control(), n, kind);
      end
    end
    in_valid <= 1'b0;

    // Let the checker take in the final byte before watching its queue.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes, %0d frame ends predicted, %0d results checked.",
             bytes_sent, frames_closed, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results outstanding.", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/cmuxr_pkg.sv
rtl/cmuxr_crc.sv
rtl/cmuxr_store.sv
rtl/cmux_basic_frame_receiver.sv
verif/cmux_frame_checker.sv
verif/cmux_basic_frame_receiver_tb.sv
